/* rtl/ucc_pkg.sv */
`default_nettype none

package ucc_pkg;

    localparam int NumStages = 7;

    localparam logic [25:0] DayRecip  = 26'd50903317;
    localparam logic [15:0] YearRecip = 16'd45934;
    localparam logic [12:0] HourRecip = 13'd4661;
    localparam logic [10:0] MinRecip  = 11'd1093;
    localparam logic [9:0]  CentRecip = 10'd656;

    localparam logic [15:0] LeapSkipDay = 16'd47541;
    localparam logic [9:0]  LeapsTo1969 = 10'd477;
    localparam logic [11:0] EpochYear   = 12'd1970;

    typedef enum logic {
        CMD_SEC_TO_CAL = 1'b0,
        CMD_CAL_TO_SEC = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        command;
        logic [31:0] in_seconds;
        logic [11:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_seconds;
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
    } out_item_t;

    typedef struct packed {
        logic        command;
        logic [31:0] ts;
        logic [15:0] days;
        logic [16:0] rem;
        logic [15:0] dshift;
        logic [5:0]  cyc;
        logic [10:0] r;
        logic [1:0]  yi;
        logic [4:0]  hour;
        logic [11:0] rem2;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [8:0]  doy;
        logic [11:0] year;
        logic        leapf;
        logic [3:0]  month;
        logic [11:0] y;
        logic [3:0]  mon;
        logic [4:0]  dd;
        logic [5:0]  q100a;
        logic [5:0]  q100b;
        logic [3:0]  q400b;
        logic [16:0] hms;
        logic [31:0] cdays;
        logic [31:0] secs;
        out_item_t   res;
    } pipe_t;

    function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        case (month)
            4'd0, 4'd1: base = 9'd0;
            4'd2:       base = 9'd31;
            4'd3:       base = 9'd59;
            4'd4:       base = 9'd90;
            4'd5:       base = 9'd120;
            4'd6:       base = 9'd151;
            4'd7:       base = 9'd181;
            4'd8:       base = 9'd212;
            4'd9:       base = 9'd243;
            4'd10:      base = 9'd273;
            4'd11:      base = 9'd304;
            4'd12:      base = 9'd334;
            default:    base = 9'd365;
        endcase
        if (leap && month >= 4'd3 && month <= 4'd12) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

`default_nettype wire

/* rtl/unix_calendar_converter.sv */
// Channel  | Ports                        | Payload
// s_       | s_valid, s_ready, s_data     | ucc_pkg::in_item_t, one request
// m_       | m_valid, m_ready, m_data     | ucc_pkg::out_item_t, one result
//
// Seven register stages, one transaction in per cycle while the output is not stalled.
// The depth is set by the reciprocal multiplies (day, 4-year cycle, hour, minute).
// aresetn (synchronous) clears the stage valid bits; payload is not reset.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module unix_calendar_converter (
    input  wire                logic aclk,
    input  wire                logic aresetn,
    input  wire                logic s_valid,
    output                     logic s_ready,
    input  ucc_pkg::in_item_t        s_data,
    output                     logic m_valid,
    input  wire                logic m_ready,
    output ucc_pkg::out_item_t       m_data
);
    import ucc_pkg::*;

    pipe_t                 p_reg  [NumStages];
    pipe_t                 p_next [NumStages];
    logic [NumStages-1:0]  vld_reg;
    logic [NumStages-1:0]  vld_next;
    logic                  advance;

    assign advance = !vld_reg[NumStages-1] || m_ready;
    assign s_ready = advance;
    assign m_valid = vld_reg[NumStages-1];
    assign m_data  = p_reg[NumStages-1].res;
    assign vld_next = {vld_reg[NumStages-2:0], s_valid};

    always_comb begin
        logic [50:0] day_prod;
        logic [19:0] q100a_prod;
        logic [19:0] q100b_prod;
        logic [17:0] q400b_prod;
        logic [11:0] ym1;
        logic [32:0] day_sec;
        logic [9:0]  leaps;
        logic [19:0] year_days;
        logic        leap_y;
        logic [31:0] d_prod;
        logic [25:0] hour_prod;
        logic [20:0] min_prod;
        logic [3:0]  mcount;
        pipe_t       n;

        // stage 0: day count, century quotients, time of day
        n = '0;
        n.command = s_data.command;
        n.ts      = s_data.in_seconds;
        n.y       = s_data.in_year;
        n.mon     = s_data.in_month;
        n.dd      = s_data.in_day;
        day_prod  = 51'(s_data.in_seconds[31:7]) * 51'(DayRecip);
        n.days    = day_prod[50:35];
        ym1       = s_data.in_year - 12'd1;
        q100a_prod = 20'(s_data.in_year[11:2]) * 20'(CentRecip);
        q100b_prod = 20'(ym1[11:2]) * 20'(CentRecip);
        q400b_prod = 18'(ym1[11:4]) * 18'(CentRecip);
        n.q100a   = q100a_prod[19:14];
        n.q100b   = q100b_prod[19:14];
        n.q400b   = q400b_prod[17:14];
        n.hms     = 17'(s_data.in_hour) * 17'd3600 + 17'(s_data.in_minute) * 17'd60
                    + 17'(s_data.in_second);
        p_next[0] = n;

        // stage 1: second of day, shifted day count, calendar day total
        n = p_reg[0];
        day_sec  = 33'(n.days) * 33'd86400;
        n.rem    = n.ts[16:0] - day_sec[16:0];
        n.dshift = n.days + 16'd365 + 16'(n.days >= LeapSkipDay);
        leap_y   = (n.y[1:0] == 2'b00)
                   && ((12'(n.q100a) * 12'd100 != n.y) || (n.q100a[1:0] == 2'b00));
        ym1      = n.y - 12'd1;
        leaps    = 10'(ym1[11:2]) - 10'(n.q100b) + 10'(n.q400b);
        year_days = (n.y > EpochYear)
                    ? 20'(n.y - EpochYear) * 20'd365 + 20'(leaps) - 20'(LeapsTo1969)
                    : 20'd0;
        n.cdays  = 32'(year_days) + 32'(month_start(n.mon, 1'b0))
                   + 32'(n.mon > 4'd2 && leap_y) + 32'(n.dd) - 32'd1;
        p_next[1] = n;

        // stage 2: 4-year cycle, hour, calendar seconds
        n = p_reg[1];
        d_prod    = 32'(n.dshift) * 32'(YearRecip);
        n.cyc     = d_prod[31:26];
        hour_prod = 26'(n.rem[16:4]) * 26'(HourRecip);
        n.hour    = hour_prod[24:20];
        n.secs    = n.cdays * 32'd86400 + 32'(n.hms);
        p_next[2] = n;

        // stage 3: day within cycle, year within cycle, second of hour
        n = p_reg[2];
        n.r    = 11'(n.dshift - 16'(n.cyc) * 16'd1461);
        n.yi   = 2'(n.r >= 11'd365) + 2'(n.r >= 11'd730) + 2'(n.r >= 11'd1095);
        n.rem2 = 12'(n.rem - 17'(n.hour) * 17'd3600);
        p_next[3] = n;

        // stage 4: day of year, year, minute
        n = p_reg[3];
        n.doy    = 9'(n.r - 11'(n.yi) * 11'd365);
        n.year   = 12'(n.cyc) * 12'd4 + 12'(n.yi) + 12'd1969;
        n.leapf  = (n.yi == 2'd3);
        min_prod = 21'(n.rem2[11:2]) * 21'(MinRecip);
        n.minute = min_prod[19:14];
        p_next[4] = n;

        // stage 5: month, second
        n = p_reg[4];
        mcount = 4'd1;
        for (int i = 2; i <= 12; i++) begin
            if (n.doy >= month_start(4'(i), n.leapf)) begin
                mcount = 4'(i);
            end
        end
        n.month  = mcount;
        n.second = 6'(n.rem2 - 12'(n.minute) * 12'd60);
        p_next[5] = n;

        // stage 6: day of month, result select
        n = p_reg[5];
        n.res = '0;
        if (cmd_t'(n.command) == CMD_CAL_TO_SEC) begin
            n.res.out_seconds = n.secs;
        end else begin
            n.res.out_year   = n.year;
            n.res.out_month  = n.month;
            n.res.out_day    = 5'(n.doy - month_start(n.month, n.leapf) + 9'd1);
            n.res.out_hour   = n.hour;
            n.res.out_minute = n.minute;
            n.res.out_second = n.second;
        end
        p_next[6] = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p_reg <= p_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transaction lost at first stage");

    a_cal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (p_reg[NumStages-1].command == CMD_SEC_TO_CAL) |->
            m_data.out_month >= 4'd1 && m_data.out_month <= 4'd12 && m_data.out_day >= 5'd1
            && m_data.out_hour < 5'd24 && m_data.out_minute < 6'd60
            && m_data.out_second < 6'd60 && m_data.out_seconds == 32'd0)
        else $error("calendar result out of range");

    a_sec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (p_reg[NumStages-1].command == CMD_CAL_TO_SEC) |->
            m_data.out_year == 12'd0 && m_data.out_month == 4'd0 && m_data.out_day == 5'd0
            && m_data.out_hour == 5'd0 && m_data.out_minute == 6'd0
            && m_data.out_second == 6'd0)
        else $error("calendar fields not cleared for seconds result");

endmodule

`default_nettype wire
